>>> src/gcb_pkg.sv
package gcb_pkg;

    localparam int ADJ_W     = 64;
    localparam int ADJ_IDX_W = 6;
    localparam int RCNT_W    = 4;
    localparam int CCNT_W    = 3;
    localparam int REGION_W  = 3;
    localparam int COLOR_W   = 3;
    localparam int TRIAL_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ADJACENCY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT  = 2'd2;

    localparam logic [RCNT_W-1:0] RCNT_RESET = 4'd7;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 3'd4;

    // datapath operation of one step
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_INIT,
        OP_NONE,
        OP_INC,
        OP_PLACE,
        OP_BACK,
        OP_EMIT,
        OP_FAIL
    } t_op;

    // branch condition of one step
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_OVER,
        C_CLASH,
        C_DLAST,
        C_DZERO,
        C_ELAST,
        C_FREE
    } t_cond;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_INIT,
        ST_TEST,
        ST_CHECK,
        ST_BUMP,
        ST_PLACE,
        ST_BACK,
        ST_EMIT_FAIL
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jt;
        t_step jf;
    } t_uword;

    typedef struct packed {
        logic c_over;
        logic clash;
        logic d_last;
        logic d_zero;
        logic e_last;
    } t_flags;

    typedef struct packed {
        logic                found;
        logic [REGION_W-1:0] region;
        logic [COLOR_W-1:0]  region_color;
        logic                last;
    } t_result;

    // Control store. ST_EMIT_FAIL is reached two ways in name only: the
    // emit loop lives in ST_EMIT below, packed as the last free code.
    localparam t_step ST_EMIT = ST_EMIT_FAIL;

    function automatic t_uword gcb_urom(input t_step s, input logic fail_path);
        t_uword w;
        w = '{op: OP_NONE, cond: C_ALWAYS, jt: ST_WAIT, jf: ST_WAIT};
        unique case (s)
            ST_WAIT:  w = '{op: OP_WAIT,  cond: C_START,  jt: ST_INIT,  jf: ST_WAIT};
            ST_INIT:  w = '{op: OP_INIT,  cond: C_ALWAYS, jt: ST_TEST,  jf: ST_TEST};
            ST_TEST:  w = '{op: OP_NONE,  cond: C_OVER,   jt: ST_BACK,  jf: ST_CHECK};
            ST_CHECK: w = '{op: OP_NONE,  cond: C_CLASH,  jt: ST_BUMP,  jf: ST_PLACE};
            ST_BUMP:  w = '{op: OP_INC,   cond: C_ALWAYS, jt: ST_TEST,  jf: ST_TEST};
            ST_PLACE: w = '{op: OP_PLACE, cond: C_DLAST,  jt: ST_EMIT,  jf: ST_TEST};
            ST_BACK:  w = '{op: OP_BACK,  cond: C_DZERO,  jt: ST_EMIT,  jf: ST_TEST};
            ST_EMIT_FAIL: begin
                if (fail_path) begin
                    w = '{op: OP_FAIL, cond: C_FREE,  jt: ST_WAIT, jf: ST_EMIT};
                end else begin
                    w = '{op: OP_EMIT, cond: C_ELAST, jt: ST_WAIT, jf: ST_EMIT};
                end
            end
            default:  w = '{op: OP_NONE,  cond: C_ALWAYS, jt: ST_WAIT,  jf: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> src/gcb_ifs.sv
interface gcb_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

interface gcb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [gcb_pkg::REGION_W-1:0]  region;
    logic [gcb_pkg::COLOR_W-1:0]   region_color;
    logic                          last;

    modport source (output valid, output found, output region, output region_color,
                    output last, input ready);
    modport sink   (input valid, input found, input region, input region_color,
                    input last, output ready);
endinterface

interface gcb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gcb_pkg::CFG_IDX_W-1:0] index;
    logic [gcb_pkg::ADJ_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/gcb_seq.sv
module gcb_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gcb_pkg::t_flags i_flags,
    input  logic            i_start,
    input  logic            i_out_free,
    output gcb_pkg::t_op    o_op
);

    gcb_pkg::t_step  r_step, n_step;
    logic            r_fail, n_fail;
    gcb_pkg::t_uword w_uw;
    logic            w_take;

    assign w_uw = gcb_pkg::gcb_urom(r_step, r_fail);
    assign o_op = w_uw.op;

    always_comb begin
        unique case (w_uw.cond)
            gcb_pkg::C_ALWAYS: w_take = 1'b1;
            gcb_pkg::C_START:  w_take = i_start;
            gcb_pkg::C_OVER:   w_take = i_flags.c_over;
            gcb_pkg::C_CLASH:  w_take = i_flags.clash;
            gcb_pkg::C_DLAST:  w_take = i_flags.d_last;
            gcb_pkg::C_DZERO:  w_take = i_flags.d_zero;
            gcb_pkg::C_ELAST:  w_take = i_out_free & i_flags.e_last;
            gcb_pkg::C_FREE:   w_take = i_out_free;
            default:           w_take = 1'b0;
        endcase
        n_step = w_take ? w_uw.jt : w_uw.jf;
        // remember which way the output step was entered
        n_fail = r_fail;
        if (w_uw.op == gcb_pkg::OP_BACK) begin
            n_fail = 1'b1;
        end else if (w_uw.op == gcb_pkg::OP_PLACE || w_uw.op == gcb_pkg::OP_INIT) begin
            n_fail = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= gcb_pkg::ST_WAIT;
            r_fail <= 1'b0;
        end else begin
            r_step <= n_step;
            r_fail <= n_fail;
        end
    end

endmodule

>>> src/gcb_datapath.sv
module gcb_datapath #(
    parameter int REGIONS = 8,
    parameter int DW      = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcb_pkg::t_op                  i_op,
    input  logic                          i_out_free,
    input  logic [gcb_pkg::ADJ_W-1:0]     i_adj,
    input  logic [DW-1:0]                 i_last_idx,
    input  logic [gcb_pkg::CCNT_W-1:0]    i_colors,
    output gcb_pkg::t_flags               o_flags,
    output gcb_pkg::t_result              o_res
);

    logic [gcb_pkg::COLOR_W-1:0] r_stack [REGIONS];
    logic [DW-1:0]               r_d;
    logic [DW-1:0]               r_e;
    logic [gcb_pkg::TRIAL_W-1:0] r_c;
    logic [REGIONS-1:0]          w_hit;
    logic [DW-1:0]               w_raddr;
    logic [gcb_pkg::COLOR_W-1:0] w_rdata;

    // neighbor compare against every lower, already colored region
    always_comb begin
        for (int i = 0; i < REGIONS; i++) begin
            w_hit[i] = (r_d > DW'(i))
                     & i_adj[gcb_pkg::ADJ_IDX_W'(int'(r_d) * REGIONS + i)]
                     & ({1'b0, r_stack[i]} == r_c);
        end
    end

    assign w_raddr = (i_op == gcb_pkg::OP_EMIT) ? r_e : DW'(r_d - 1'b1);
    assign w_rdata = r_stack[w_raddr];

    assign o_flags.c_over = r_c > {1'b0, i_colors};
    assign o_flags.clash  = |w_hit;
    assign o_flags.d_last = r_d == i_last_idx;
    assign o_flags.d_zero = r_d == '0;
    assign o_flags.e_last = r_e == i_last_idx;

    always_comb begin
        if (i_op == gcb_pkg::OP_FAIL) begin
            o_res = '{found: 1'b0, region: '0, region_color: '0, last: 1'b1};
        end else begin
            o_res = '{found: 1'b1, region: gcb_pkg::REGION_W'(r_e),
                      region_color: w_rdata, last: r_e == i_last_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
            r_e <= '0;
            r_c <= '0;
            for (int i = 0; i < REGIONS; i++) begin
                r_stack[i] <= '0;
            end
        end else begin
            unique case (i_op)
                gcb_pkg::OP_INIT: begin
                    r_d <= '0;
                    r_e <= '0;
                    r_c <= gcb_pkg::TRIAL_W'(1);
                    for (int i = 0; i < REGIONS; i++) begin
                        r_stack[i] <= '0;
                    end
                end
                gcb_pkg::OP_INC: begin
                    r_c <= r_c + 1'b1;
                end
                gcb_pkg::OP_PLACE: begin
                    r_stack[r_d] <= r_c[gcb_pkg::COLOR_W-1:0];
                    if (r_d != i_last_idx) begin
                        r_d <= r_d + 1'b1;
                        r_c <= gcb_pkg::TRIAL_W'(1);
                    end
                end
                gcb_pkg::OP_BACK: begin
                    r_stack[r_d] <= '0;
                    if (r_d != '0) begin
                        r_d <= r_d - 1'b1;
                        r_c <= {1'b0, w_rdata} + 1'b1;
                    end
                end
                gcb_pkg::OP_EMIT: begin
                    if (i_out_free) begin
                        r_e <= r_e + 1'b1;
                    end
                end
                gcb_pkg::OP_WAIT, gcb_pkg::OP_NONE, gcb_pkg::OP_FAIL: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/graph_coloring_backtrack.sv
// Channel   Dir   Word                                   Handshake
// i_in      in    start_req                              valid/ready
// o_out     out   found, region, region_color, last      valid/ready
// i_cfg     in    index, data (adjacency/count regs)     valid/ready, ready always high
//
// Each search step is one sequencer state: a color trial costs test, check and bump steps,
// a backtrack costs back and test steps, and each result word an emit step;
// the worst case grows as color_count to the power region_count.
// Input is taken only in the wait step; a start_req of 0 is taken and dropped.
// Reset (synchronous, active low) clears the sequencer, the color stack and the
// config registers to adjacency 0, region_count 7, color_count 4.
// A stalled output holds its word and the emit step; the next start can be taken while the last word waits.
module graph_coloring_backtrack #(
    parameter int REGIONS    = 8,
    parameter int MAX_COLORS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gcb_in_if.sink    i_in,
    gcb_out_if.source o_out,
    gcb_cfg_if.sink   i_cfg
);

    localparam int DW = $clog2(REGIONS);

    logic [gcb_pkg::ADJ_W-1:0]  r_adj;
    logic [gcb_pkg::RCNT_W-1:0] r_rcnt;
    logic [gcb_pkg::CCNT_W-1:0] r_ccnt;

    logic [DW-1:0]              w_last_idx;
    logic [gcb_pkg::CCNT_W-1:0] w_colors;

    gcb_pkg::t_op     w_op;
    gcb_pkg::t_flags  w_flags;
    gcb_pkg::t_result w_res;
    gcb_pkg::t_result r_out;
    logic             r_ovalid;
    logic             w_out_free;
    logic             w_load;
    logic             w_start;

    // config writes land directly; writes to an unknown index are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj  <= '0;
            r_rcnt <= gcb_pkg::RCNT_RESET;
            r_ccnt <= gcb_pkg::CCNT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gcb_pkg::CFG_ADJACENCY) begin
                r_adj <= i_cfg.data;
            end else if (i_cfg.index == gcb_pkg::CFG_REGION_COUNT) begin
                r_rcnt <= i_cfg.data[gcb_pkg::RCNT_W-1:0];
            end else if (i_cfg.index == gcb_pkg::CFG_COLOR_COUNT) begin
                r_ccnt <= i_cfg.data[gcb_pkg::CCNT_W-1:0];
            end
        end
    end

    // clamp region count to 1..REGIONS, kept as index of the final region
    always_comb begin
        priority if (r_rcnt == '0) begin
            w_last_idx = '0;
        end else if (r_rcnt > gcb_pkg::RCNT_W'(REGIONS)) begin
            w_last_idx = DW'(REGIONS - 1);
        end else begin
            w_last_idx = DW'(r_rcnt - 1'b1);
        end
    end

    // saturate color count at MAX_COLORS; zero simply fails the search
    assign w_colors = (r_ccnt > gcb_pkg::CCNT_W'(MAX_COLORS)) ?
                      gcb_pkg::CCNT_W'(MAX_COLORS) : r_ccnt;

    // input side: only the wait step takes a word
    assign i_in.ready = (w_op == gcb_pkg::OP_WAIT);
    assign w_start    = i_in.valid & i_in.ready & i_in.start_req;

    // output register: free when empty or being drained this cycle
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_load     = w_out_free &&
                        (w_op == gcb_pkg::OP_EMIT || w_op == gcb_pkg::OP_FAIL);

    gcb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_op       (w_op)
    );

    gcb_datapath #(
        .REGIONS (REGIONS),
        .DW      (DW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_out_free (w_out_free),
        .i_adj      (r_adj),
        .i_last_idx (w_last_idx),
        .i_colors   (w_colors),
        .o_flags    (w_flags),
        .o_res      (w_res)
    );

    // hold the word until taken, load the next one in the same edge if free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.found        = r_out.found;
    assign o_out.region       = r_out.region;
    assign o_out.region_color = r_out.region_color;
    assign o_out.last         = r_out.last;

endmodule
